>>> src/first_fit_coalescing_allocator_macros.svh
// assertion macros for the first-fit allocator
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define FFCA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ffca assertion failed");
// condition must never be true
`define FFCA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ffca forbidden condition seen");
`else
`define FFCA_ASSERT(lbl, clk, rstn, prop)
`define FFCA_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> src/ffca_pkg.sv
// shared constants for the first-fit allocator
`timescale 1ns / 1ps
package ffca_pkg;

  // word field widths
  localparam int unsigned BYTES_W = 21;
  localparam int unsigned PAY_W   = 17;

  // unit size as a shift
  localparam int unsigned UNIT_SHIFT = 4;
  localparam int unsigned UNIT_BYTES = 1 << UNIT_SHIFT;
  localparam int unsigned NEED_W     = BYTES_W + 1 - UNIT_SHIFT;

  // list heads and the first block
  localparam int unsigned FREE_HEAD   = 0;
  localparam int unsigned ALLOC_HEAD  = 1;
  localparam int unsigned FIRST_BLOCK = 2;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

endpackage

>>> src/first_fit_coalescing_allocator.sv
// first-fit allocator: one word per request; each list step reads a header and then uses it, and the writes follow
// an allocate walks the free list, then the allocated list
// a free walks the allocated list, then the free list
// each step is one read of the header memory, which sets the pace
// reset clears the registers but not the header memory; that is built by the first request in S_INIT0 to S_INIT2
// the next request is taken while a finished result waits in the output register
`timescale 1ns / 1ps
module first_fit_coalescing_allocator import ffca_pkg::*; #(
  parameter int unsigned ARENA_UNITS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [BYTES_W-1:0] request_bytes_i,
  input  logic [PAY_W-1:0]   release_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [PAY_W-1:0]   payload_index_o
);

`include "first_fit_coalescing_allocator_macros.svh"

  localparam int unsigned DEPTH = ARENA_UNITS + 3;
  localparam int unsigned IW    = $clog2(ARENA_UNITS + 4);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(ARENA_UNITS + 1);
  localparam int unsigned DW    = SW + IW;
  localparam int unsigned MW    = (IW > SW) ? IW : SW;
  localparam int unsigned CW    = ((MW > NEED_W) ? MW : NEED_W) + 2;
  localparam logic [IW-1:0] END_IDX = IW'(ARENA_UNITS + 3);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_DISPATCH,
    S_AF_RD, S_AF_USE, S_A_FIX, S_AA_RD, S_AA_USE,
    S_FA_RD, S_FA_USE, S_FB_RD, S_FB_USE, S_F_FIX,
    S_FF_RD, S_FF_USE, S_FJ_RD, S_FJ_USE, S_F_JOIN,
    S_WB_A, S_WB_B, S_DONE
  } state_e;

  // clamp a stored link to the list end
  function automatic logic [IW-1:0] link_of(input logic [IW-1:0] n);
    return (n > END_IDX) ? END_IDX : n;
  endfunction

  state_e              state_q;
  logic                init_q;
  logic                kind_q;
  logic                zero_q;
  logic [NEED_W-1:0]   need_q;
  logic [PAY_W-1:0]    rel_q;
  logic [IW-1:0]       addr_q;
  logic [IW-1:0]       prev_q;
  logic [SW-1:0]       psize_q;
  logic [IW-1:0]       idx_q;
  logic [SW-1:0]       bsize_q;
  logic [IW-1:0]       bnext_q;
  logic [IW-1:0]       wa_addr_q;
  logic [DW-1:0]       wa_data_q;
  logic [IW-1:0]       wb_addr_q;
  logic [DW-1:0]       wb_data_q;
  logic [1:0]          st_q;
  logic [PAY_W-1:0]    pay_q;
  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [PAY_W-1:0]    out_pay_q;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [DW-1:0]       ram_wdata;
  logic [DW-1:0]       ram_rdata;
  logic [SW-1:0]       r_size;
  logic [IW-1:0]       r_next;
  logic [IW-1:0]       r_link;
  logic [CW-1:0]       split_size;
  logic                in_acc;

  ffca_hdr_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // header fields of the word just read
  assign r_size     = ram_rdata[DW-1:IW];
  assign r_next     = ram_rdata[IW-1:0];
  assign r_link     = link_of(r_next);
  assign split_size = CW'(r_size) - CW'(need_q) - CW'(1);

  assign in_stall_o      = (state_q != S_IDLE);
  assign in_acc          = in_valid_i && !in_stall_o;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign payload_index_o = out_pay_q;

  // memory write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wa_addr_q;
    ram_wdata = wa_data_q;
    case (state_q)
      S_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(FREE_HEAD);
        ram_wdata = {SW'(0), IW'(FIRST_BLOCK)};
      end
      S_INIT1: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(ALLOC_HEAD);
        ram_wdata = {SW'(0), END_IDX};
      end
      S_INIT2: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(FIRST_BLOCK);
        ram_wdata = {SW'(ARENA_UNITS), END_IDX};
      end
      S_A_FIX, S_F_FIX, S_WB_A: begin
        ram_we = 1'b1;
      end
      S_WB_B: begin
        ram_we    = 1'b1;
        ram_waddr = wb_addr_q;
        ram_wdata = wb_data_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      init_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_ALLOC;
      zero_q       <= 1'b0;
      need_q       <= '0;
      rel_q        <= '0;
      addr_q       <= '0;
      prev_q       <= '0;
      psize_q      <= '0;
      idx_q        <= '0;
      bsize_q      <= '0;
      bnext_q      <= '0;
      wa_addr_q    <= '0;
      wa_data_q    <= '0;
      wb_addr_q    <= '0;
      wb_data_q    <= '0;
      st_q         <= ST_OK;
      pay_q        <= '0;
      out_status_q <= ST_OK;
      out_pay_q    <= '0;
    end else begin
      // the output register is reloaded in S_DONE, cleared elsewhere once taken
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q  <= kind_i;
            zero_q  <= (request_bytes_i == '0);
            need_q  <= NEED_W'((22'(request_bytes_i) + 22'(UNIT_BYTES - 1)) >> UNIT_SHIFT);
            rel_q   <= release_index_i;
            state_q <= init_q ? S_DISPATCH : S_INIT0;
          end
        end
        S_INIT0: state_q <= S_INIT1;
        S_INIT1: state_q <= S_INIT2;
        S_INIT2: begin
          init_q  <= 1'b1;
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          pay_q <= '0;
          if (kind_q == KIND_ALLOC) begin
            if (zero_q) begin
              st_q    <= ST_ZERO;
              state_q <= S_DONE;
            end else begin
              addr_q  <= IW'(FREE_HEAD);
              state_q <= S_AF_RD;
            end
          end else if (rel_q == '0) begin
            st_q    <= ST_BADFREE;
            state_q <= S_DONE;
          end else begin
            addr_q  <= IW'(ALLOC_HEAD);
            state_q <= S_FA_RD;
          end
        end
        // first-fit walk of the free list
        S_AF_RD: state_q <= S_AF_USE;
        S_AF_USE: begin
          if (CW'(r_size) < CW'(need_q)) begin
            if (r_link == END_IDX) begin
              st_q    <= ST_NOFIT;
              state_q <= S_DONE;
            end else begin
              prev_q  <= addr_q;
              psize_q <= r_size;
              addr_q  <= r_link;
              state_q <= S_AF_RD;
            end
          end else begin
            if (CW'(r_size) > CW'(need_q)) begin
              wa_addr_q <= addr_q;
              wa_data_q <= {SW'(split_size), r_next};
              idx_q     <= IW'(CW'(addr_q) + split_size + CW'(1));
            end else begin
              wa_addr_q <= prev_q;
              wa_data_q <= {psize_q, r_next};
              idx_q     <= addr_q;
            end
            state_q <= S_A_FIX;
          end
        end
        S_A_FIX: begin
          addr_q  <= IW'(ALLOC_HEAD);
          state_q <= S_AA_RD;
        end
        // ordered insert into the allocated list
        S_AA_RD: state_q <= S_AA_USE;
        S_AA_USE: begin
          if (r_link < idx_q) begin
            addr_q  <= r_link;
            state_q <= S_AA_RD;
          end else begin
            wa_addr_q <= idx_q;
            wa_data_q <= {SW'(need_q), r_link};
            wb_addr_q <= addr_q;
            wb_data_q <= {r_size, idx_q};
            st_q      <= ST_OK;
            pay_q     <= PAY_W'(CW'(idx_q) + CW'(1));
            state_q   <= S_WB_A;
          end
        end
        // search the allocated list for the target
        S_FA_RD: state_q <= S_FA_USE;
        S_FA_USE: begin
          if (r_link == END_IDX) begin
            st_q    <= ST_BADFREE;
            state_q <= S_DONE;
          end else if (CW'(r_link) + CW'(1) == CW'(rel_q)) begin
            prev_q  <= addr_q;
            psize_q <= r_size;
            addr_q  <= r_link;
            idx_q   <= r_link;
            state_q <= S_FB_RD;
          end else begin
            addr_q  <= r_link;
            state_q <= S_FA_RD;
          end
        end
        S_FB_RD: state_q <= S_FB_USE;
        S_FB_USE: begin
          bsize_q   <= r_size;
          wa_addr_q <= prev_q;
          wa_data_q <= {psize_q, r_next};
          state_q   <= S_F_FIX;
        end
        S_F_FIX: begin
          addr_q  <= IW'(FREE_HEAD);
          state_q <= S_FF_RD;
        end
        // find the place in the free list
        S_FF_RD: state_q <= S_FF_USE;
        S_FF_USE: begin
          if (r_link < idx_q) begin
            addr_q  <= r_link;
            state_q <= S_FF_RD;
          end else begin
            prev_q  <= addr_q;
            psize_q <= r_size;
            bnext_q <= r_link;
            if (r_link != END_IDX) begin
              addr_q  <= r_link;
              state_q <= S_FJ_RD;
            end else begin
              state_q <= S_F_JOIN;
            end
          end
        end
        // merge with the following block
        S_FJ_RD: state_q <= S_FJ_USE;
        S_FJ_USE: begin
          if (CW'(idx_q) + CW'(bsize_q) + CW'(1) == CW'(addr_q)) begin
            bsize_q <= SW'(CW'(bsize_q) + CW'(r_size) + CW'(1));
            bnext_q <= r_next;
          end
          state_q <= S_F_JOIN;
        end
        // merge with the preceding block
        S_F_JOIN: begin
          wa_addr_q <= idx_q;
          wa_data_q <= {bsize_q, bnext_q};
          wb_addr_q <= prev_q;
          if (CW'(prev_q) + CW'(psize_q) + CW'(1) == CW'(idx_q)) begin
            wb_data_q <= {SW'(CW'(psize_q) + CW'(bsize_q) + CW'(1)), bnext_q};
          end else begin
            wb_data_q <= {psize_q, idx_q};
          end
          st_q    <= ST_OK;
          state_q <= S_WB_A;
        end
        S_WB_A: state_q <= S_WB_B;
        S_WB_B: state_q <= S_DONE;
        // hand the word to the output register
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= st_q;
            out_pay_q    <= pay_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  `FFCA_ASSERT(a_pay_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK |-> payload_index_o == '0)
  `FFCA_ASSERT(a_busy_after_acc, clk_i, rst_ni, in_acc |=> in_stall_o)
  `FFCA_ASSERT_NEVER(a_wr_range, clk_i, rst_ni, ram_we && (ram_waddr >= END_IDX))

endmodule

>>> src/ffca_hdr_ram.sv
// header memory: one write port, one registered read port
`timescale 1ns / 1ps
module ffca_hdr_ram import ffca_pkg::*; #(
  parameter int unsigned DEPTH = 65539,
  parameter int unsigned AW    = 17,
  parameter int unsigned DW    = 34
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sim/tb_first_fit_coalescing_allocator.sv
// self-checking testbench for the first-fit coalescing allocator
`timescale 1ns / 1ps
module tb_first_fit_coalescing_allocator;
  import ffca_pkg::*;

  localparam int unsigned ARENA     = 65536;
  localparam int unsigned DEPTH     = ARENA + 3;
  localparam int unsigned END_LINK  = ARENA + 3;
  localparam int unsigned CYCLE_CAP = 30_000_000;

  typedef struct packed {
    logic [1:0]       status;
    logic [PAY_W-1:0] payload;
  } grant_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               kind_i = KIND_ALLOC;
  logic [BYTES_W-1:0] request_bytes_i = '0;
  logic [PAY_W-1:0]   release_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [PAY_W-1:0]   payload_index_o;

  // header mirror of the arena
  int unsigned hdr_size [DEPTH];
  int unsigned hdr_next [DEPTH];
  bit          arena_built = 1'b0;

  grant_t      grants_due[$];
  int unsigned live_blocks[$];
  int unsigned last_released = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  first_fit_coalescing_allocator #(.ARENA_UNITS(ARENA)) i_dut (.*);

  always #10 clk_i = ~clk_i;

  // link of a header, clamped to the end marker
  function automatic int unsigned link(int unsigned i);
    return (hdr_next[i] > END_LINK) ? END_LINK : hdr_next[i];
  endfunction

  function automatic void merge_blocks(int unsigned a, int unsigned b);
    if (a + 1 + hdr_size[a] == b) begin
      hdr_size[a] += hdr_size[b] + 1;
      hdr_next[a] = hdr_next[b];
    end
  endfunction

  // first-fit grant with tail split
  function automatic grant_t predict_alloc(int unsigned bytes);
    int unsigned need, p, pn, idx;
    grant_t g;
    g = '{status: ST_OK, payload: '0};
    if (bytes == 0) begin
      g.status = ST_ZERO;
      return g;
    end
    need = (bytes + UNIT_BYTES - 1) / UNIT_BYTES;
    p = FREE_HEAD;
    while (link(p) != END_LINK && hdr_size[link(p)] < need) p = link(p);
    if (link(p) == END_LINK) begin
      g.status = ST_NOFIT;
      return g;
    end
    pn = link(p);
    idx = pn;
    if (hdr_size[pn] > need) begin
      hdr_size[pn] -= need + 1;
      idx = pn + hdr_size[pn] + 1;
      pn = idx;
      hdr_size[pn] = need;
    end else begin
      hdr_next[p] = hdr_next[pn];
    end
    p = ALLOC_HEAD;
    while (link(p) < idx) p = link(p);
    hdr_next[pn] = link(p);
    hdr_next[p] = idx;
    g.payload = PAY_W'(idx + 1);
    return g;
  endfunction

  // release back to the free list with merging
  function automatic grant_t predict_free(int unsigned rel);
    int unsigned target, p, after;
    grant_t g;
    g = '{status: ST_BADFREE, payload: '0};
    if (rel == 0) return g;
    target = rel - 1;
    p = ALLOC_HEAD;
    while (link(p) != END_LINK && link(p) != target) p = link(p);
    if (link(p) == END_LINK) return g;
    hdr_next[p] = hdr_next[target];
    p = FREE_HEAD;
    while (link(p) < target) p = link(p);
    after = link(p);
    hdr_next[target] = after;
    hdr_next[p] = target;
    if (after != END_LINK) merge_blocks(target, after);
    merge_blocks(p, target);
    g.status = ST_OK;
    return g;
  endfunction

  function automatic grant_t predict_word(logic kind, int unsigned bytes, int unsigned rel);
    grant_t g;
    if (!arena_built) begin
      hdr_size[FREE_HEAD] = 0;
      hdr_next[FREE_HEAD] = FIRST_BLOCK;
      hdr_size[ALLOC_HEAD] = 0;
      hdr_next[ALLOC_HEAD] = END_LINK;
      hdr_size[FIRST_BLOCK] = ARENA;
      hdr_next[FIRST_BLOCK] = END_LINK;
      arena_built = 1'b1;
    end
    if (kind == KIND_ALLOC) begin
      g = predict_alloc(bytes);
      if (g.status == ST_OK) live_blocks.push_back(32'(g.payload));
    end else begin
      g = predict_free(rel);
      if (g.status == ST_OK) begin
        foreach (live_blocks[k])
          if (live_blocks[k] == rel) begin
            live_blocks.delete(k);
            break;
          end
        last_released = rel;
      end
    end
    return g;
  endfunction

  // offer one word, predict on acceptance, gap at burst end
  task automatic send_word(logic kind, int unsigned bytes, int unsigned rel);
    logic [BYTES_W-1:0] req;
    logic [PAY_W-1:0]   idx;
    req = BYTES_W'(bytes);
    idx = PAY_W'(rel);
    in_valid_i <= 1'b1;
    kind_i <= kind;
    request_bytes_i <= req;
    release_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    grants_due.push_back(predict_word(kind, 32'(req), 32'(idx)));
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic release_bus();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (grants_due.size() != 0) @(posedge clk_i);
  endtask

  // extremes and every special case on a fresh arena
  task automatic test_directed();
    send_word(KIND_ALLOC, 0, '1);                 // zero size, builds the arena
    send_word(KIND_ALLOC, 1048576, 0);            // exact fit of the whole arena
    send_word(KIND_ALLOC, 16, 0);                 // nothing left
    send_word(KIND_FREE, '1, 0);                  // null release
    send_word(KIND_FREE, 0, 3);                   // whole arena back
    send_word(KIND_FREE, 0, 3);                   // double release
    send_word(KIND_ALLOC, 1048560, 0);            // near fit leaves an empty block
    send_word(KIND_FREE, 0, 4);                   // merges with the empty block
    send_word(KIND_ALLOC, '1, 0);                 // far beyond the arena
    send_word(KIND_ALLOC, 1048577, 0);            // one byte too many
    send_word(KIND_ALLOC, 1, '1);
    send_word(KIND_ALLOC, 17, 0);
    send_word(KIND_ALLOC, 32, 0);
    send_word(KIND_ALLOC, 15, 0);
    send_word(KIND_FREE, '1, 65538 - 3);          // middle block, neighbours allocated
    send_word(KIND_FREE, 0, 65538);               // merges with the free tail
    send_word(KIND_FREE, 0, '1);                  // unknown index
    send_word(KIND_FREE, 0, 65539);
    send_word(KIND_FREE, 0, 65538 - 6);           // merges with the following free block
    send_word(KIND_FREE, 0, 65538 - 3);
    send_word(KIND_ALLOC, 32'h0AAAAA, 0);
    send_word(KIND_ALLOC, 32'h155555, 0);
    release_bus();
    wait_drained();
  endtask

  task automatic random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (live_blocks.size() > 40) r = 60;
    if (r < 50) begin
      if ($urandom_range(0, 19) == 0)
        send_word(KIND_ALLOC, $urandom_range(1, 400000), $urandom);
      else if ($urandom_range(0, 29) == 0)
        send_word(KIND_ALLOC, $urandom, $urandom);
      else
        send_word(KIND_ALLOC, $urandom_range(1, 1024), $urandom);
    end else if (r < 90 && live_blocks.size() != 0) begin
      send_word(KIND_FREE, $urandom,
                live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
    end else begin
      case ($urandom_range(0, 3))
        0: send_word(KIND_FREE, $urandom, $urandom);
        1: send_word(KIND_FREE, $urandom, 0);
        2: send_word(KIND_FREE, $urandom, last_released);
        default: send_word(KIND_ALLOC, 0, $urandom);
      endcase
    end
  endtask

  task automatic test_random();
    repeat (650) random_word();
    release_bus();
  endtask

  // long receiver hold-off while words keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    burst_left = 60;
    repeat (40) random_word();
    release_bus();
  endtask

  // sender waits once, midway, for all results before going on
  task automatic test_drain_pause();
    repeat (20) random_word();
    release_bus();
    wait_drained();
    repeat (20) random_word();
    release_bus();
  endtask

  // receiver stall pattern with a long hold on request
  always @(posedge clk_i) begin : receiver
    static int unsigned hold_left = 0;
    static int unsigned phase_left = 0;
    static int unsigned stall_pct = 0;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 600;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 300);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      phase_left--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected word status=%0d payload=%0d", $time, status_o,
                 payload_index_o);
        errors++;
      end else begin
        want = grants_due.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
        if (payload_index_o !== want.payload) begin
          $display("%0t: payload_index expected %0d actual %0d", $time, want.payload,
                   payload_index_o);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
